// File: design/csts_pkg.sv
// ----------------------------------------------------------------------------
// csts_pkg
// Shared types and constants for the shift-token scanner.
// ----------------------------------------------------------------------------
package csts_pkg;

  localparam int unsigned LINE_BITS_DEF   = 20;
  localparam int unsigned COLUMN_BITS_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF = 24;

  // Fixed widths of the result fields
  localparam int unsigned HIT_LINE_W   = 20;
  localparam int unsigned HIT_COLUMN_W = 16;
  localparam int unsigned HIT_OFFSET_W = 24;
  localparam int unsigned STATUS_W     = 2;

  localparam logic [STATUS_W-1:0] KIND_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] KIND_LT   = 2'd1;
  localparam logic [STATUS_W-1:0] KIND_GT   = 2'd2;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOTE  = 8'h27;

  typedef enum logic [3:0] {
    M_NORMAL,
    M_P_PAREN,
    M_P_SLASH,
    M_P_LT,
    M_P_GT,
    M_STRING,
    M_STR_QUOTE,
    M_BRACE,
    M_PAREN,
    M_PAREN_STAR,
    M_LINE
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t             mode_nxt;
    logic                  capture;   // latch current position as pending
    logic [STATUS_W-1:0]   kind;      // pair completed by this byte
  } lex_upd_t;

endpackage

// File: design/comment_aware_shift_token_scanner.sv
// ----------------------------------------------------------------------------
// comment_aware_shift_token_scanner
// Finds the first "<<" or ">>" in plain source text, outside strings and
// comments, and reports its line, column and byte offset.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes enter on the in_ channel (valid/ready), one per transfer,
//   with in_last set on the final byte of a buffer. Each buffer produces
//   exactly one transfer on the out_ channel: status (0 clean, 1 "<<",
//   2 ">>") and the position of the pair's first character, zero if clean.
//   The lexer state and position counters update at the edge that
//   accepts a byte, and the result is registered, so it appears on
//   out_valid the cycle after the last byte is accepted.
//   Throughput is one byte per cycle while in_ready is high.
//   A pending result does not block input as long as out_ready takes it;
//   while out_valid is high and out_ready low, in_ready is low.
//   Reset clears the lexer to plain text, line and column to one and the
//   offset to zero; the same happens after every last byte. Counters
//   saturate at their widths.
// ----------------------------------------------------------------------------
module comment_aware_shift_token_scanner #(
  parameter int unsigned LINE_BITS   = csts_pkg::LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = csts_pkg::COLUMN_BITS_DEF,
  parameter int unsigned OFFSET_BITS = csts_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [csts_pkg::STATUS_W-1:0]        out_status,
  output logic [csts_pkg::HIT_LINE_W-1:0]      out_hit_line,
  output logic [csts_pkg::HIT_COLUMN_W-1:0]    out_hit_column,
  output logic [csts_pkg::HIT_OFFSET_W-1:0]    out_hit_offset
);
  import csts_pkg::*;

  lex_mode_t               mode_r, mode_nxt;
  logic [LINE_BITS-1:0]    line_r, line_nxt, pline_r, pline_nxt;
  logic [COLUMN_BITS-1:0]  col_r, col_nxt, pcol_r, pcol_nxt;
  logic [OFFSET_BITS-1:0]  off_r, off_nxt, poff_r, poff_nxt;
  logic [STATUS_W-1:0]     kind_r, kind_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic [HIT_LINE_W-1:0]   hline_r, hline_nxt;
  logic [HIT_COLUMN_W-1:0] hcol_r, hcol_nxt;
  logic [HIT_OFFSET_W-1:0] hoff_r, hoff_nxt;

  logic     xfer;
  lex_upd_t upd;
  logic [31:0] pline_ext, pcol_ext, poff_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign xfer     = in_valid && in_ready;

  csts_lexer u_lexer (
    .mode      (mode_r),
    .data_byte (in_data_byte),
    .upd       (upd)
  );

  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    off_nxt   = off_r;
    pline_nxt = pline_r;
    pcol_nxt  = pcol_r;
    poff_nxt  = poff_r;
    kind_nxt  = kind_r;
    if (xfer) begin
      // lexing stops once a pair is found
      if (kind_r == KIND_NONE) begin
        mode_nxt = upd.mode_nxt;
        kind_nxt = upd.kind;
        if (upd.capture) begin
          pline_nxt = line_r;
          pcol_nxt  = col_r;
          poff_nxt  = off_r;
        end
      end
      off_nxt = (off_r == '1) ? off_r : off_r + 1'b1;
      if (in_data_byte == CH_NL) begin
        line_nxt = (line_r == '1) ? line_r : line_r + 1'b1;
        col_nxt  = COLUMN_BITS'(1);
      end else begin
        col_nxt = (col_r == '1) ? col_r : col_r + 1'b1;
      end
    end
  end

  assign pline_ext = 32'(pline_nxt);
  assign pcol_ext  = 32'(pcol_nxt);
  assign poff_ext  = 32'(poff_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    hline_nxt     = hline_r;
    hcol_nxt      = hcol_r;
    hoff_nxt      = hoff_r;
    if (xfer && in_last) begin
      out_valid_nxt = 1'b1;
      status_nxt    = kind_nxt;
      if (kind_nxt != KIND_NONE) begin
        hline_nxt = pline_ext[HIT_LINE_W-1:0];
        hcol_nxt  = pcol_ext[HIT_COLUMN_W-1:0];
        hoff_nxt  = poff_ext[HIT_OFFSET_W-1:0];
      end else begin
        hline_nxt = '0;
        hcol_nxt  = '0;
        hoff_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (xfer && in_last)) begin
      mode_r  <= M_NORMAL;
      line_r  <= LINE_BITS'(1);
      col_r   <= COLUMN_BITS'(1);
      off_r   <= '0;
      pline_r <= '0;
      pcol_r  <= '0;
      poff_r  <= '0;
      kind_r  <= KIND_NONE;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      off_r   <= off_nxt;
      pline_r <= pline_nxt;
      pcol_r  <= pcol_nxt;
      poff_r  <= poff_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    hline_r  <= hline_nxt;
    hcol_r   <= hcol_nxt;
    hoff_r   <= hoff_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_hit_line   = hline_r;
  assign out_hit_column = hcol_r;
  assign out_hit_offset = hoff_r;

endmodule

// File: design/csts_lexer.sv
// ----------------------------------------------------------------------------
// csts_lexer
// Lexical context transition for one source byte.
// ----------------------------------------------------------------------------
module csts_lexer (
  input  csts_pkg::lex_mode_t mode,
  input  logic [7:0]          data_byte,
  output csts_pkg::lex_upd_t  upd
);
  import csts_pkg::*;

  lex_mode_t           norm_mode;
  logic                norm_cap;
  lex_mode_t           next_mode;
  logic                cap;
  logic [STATUS_W-1:0] pair_kind;

  // Byte seen in plain text with nothing pending
  always_comb begin
    norm_cap = 1'b0;
    unique case (data_byte)
      CH_QUOTE:  norm_mode = M_STRING;
      CH_LBRACE: norm_mode = M_BRACE;
      CH_LPAREN: begin norm_mode = M_P_PAREN; norm_cap = 1'b1; end
      CH_SLASH:  begin norm_mode = M_P_SLASH; norm_cap = 1'b1; end
      CH_LT:     begin norm_mode = M_P_LT;    norm_cap = 1'b1; end
      CH_GT:     begin norm_mode = M_P_GT;    norm_cap = 1'b1; end
      default:   norm_mode = M_NORMAL;
    endcase
  end

  // Next state
  always_comb begin
    next_mode = mode;
    unique case (mode)
      M_P_PAREN:   next_mode = (data_byte == CH_STAR)  ? M_PAREN : norm_mode;
      M_P_SLASH:   next_mode = (data_byte == CH_SLASH) ? M_LINE  : norm_mode;
      M_P_LT:      next_mode = (data_byte == CH_LT)    ? mode    : norm_mode;
      M_P_GT:      next_mode = (data_byte == CH_GT)    ? mode    : norm_mode;
      M_STRING:    next_mode = (data_byte == CH_QUOTE) ? M_STR_QUOTE : mode;
      M_STR_QUOTE: next_mode = (data_byte == CH_QUOTE) ? M_STRING : norm_mode;
      M_BRACE:     next_mode = (data_byte == CH_RBRACE) ? M_NORMAL : mode;
      M_PAREN:     next_mode = (data_byte == CH_STAR)  ? M_PAREN_STAR : mode;
      M_PAREN_STAR: begin
        if (data_byte == CH_RPAREN) begin
          next_mode = M_NORMAL;
        end else if (data_byte != CH_STAR) begin
          next_mode = M_PAREN;
        end
      end
      M_LINE:      next_mode = (data_byte == CH_NL) ? M_NORMAL : mode;
      default:     next_mode = norm_mode;
    endcase
  end

  // Outputs: pending capture and pair detection
  always_comb begin
    cap       = 1'b0;
    pair_kind = KIND_NONE;
    unique case (mode)
      M_P_PAREN:   cap = (data_byte != CH_STAR) && norm_cap;
      M_P_SLASH:   cap = (data_byte != CH_SLASH) && norm_cap;
      M_P_LT: begin
        if (data_byte == CH_LT) begin
          pair_kind = KIND_LT;
        end else begin
          cap = norm_cap;
        end
      end
      M_P_GT: begin
        if (data_byte == CH_GT) begin
          pair_kind = KIND_GT;
        end else begin
          cap = norm_cap;
        end
      end
      M_STR_QUOTE: cap = (data_byte != CH_QUOTE) && norm_cap;
      M_STRING, M_BRACE, M_PAREN, M_PAREN_STAR, M_LINE: cap = 1'b0;
      default:     cap = norm_cap;
    endcase
  end

  assign upd = {next_mode, cap, pair_kind};

endmodule

// File: verif/tb_comment_aware_shift_token_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_comment_aware_shift_token_scanner
// Streams source bytes into the scanner and checks every per-buffer result
// against an in-bench lexer that follows strings, comments and pending marks.
// Directed buffers cover pairs, strings, comments, hits and byte extremes.
// A long line checks wide columns, and a receiver hold-off fills the
// output and stalls the input. Random Pascal-like text with noise follows.
// Both sides insert random gaps unless a test turns them off.
// ----------------------------------------------------------------------------
module tb_comment_aware_shift_token_scanner;
  import csts_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FRAG_N = 20;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [HIT_LINE_W-1:0]   line;
    logic [HIT_COLUMN_W-1:0] column;
    logic [HIT_OFFSET_W-1:0] offset;
  } hit_t;

  typedef struct {
    lex_mode_t                    mode;
    logic [LINE_BITS_DEF-1:0]     line;
    logic [COLUMN_BITS_DEF-1:0]   column;
    logic [OFFSET_BITS_DEF-1:0]   offset;
    logic [LINE_BITS_DEF-1:0]     mark_line;
    logic [COLUMN_BITS_DEF-1:0]   mark_column;
    logic [OFFSET_BITS_DEF-1:0]   mark_offset;
    logic [STATUS_W-1:0]          kind;
  } scan_state_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [7:0]              in_data_byte;
  logic                    in_last;
  logic                    out_valid;
  logic                    out_ready;
  logic [STATUS_W-1:0]     out_status;
  logic [HIT_LINE_W-1:0]   out_hit_line;
  logic [HIT_COLUMN_W-1:0] out_hit_column;
  logic [HIT_OFFSET_W-1:0] out_hit_offset;

  scan_state_t scan;
  hit_t        expected_hits[$];
  hit_t        want;
  int          mismatches;
  int          idle_cycles;
  int          hold_len;
  int          sink_wait;
  bit          src_idle_on;
  bit          sink_idle_on;

  string frag_tbl [FRAG_N] = '{"<<", ">>", "<", ">", "{", "}", "(*", "*)", "(", ")",
                               "*", "'", "''", "//", "/", "\n", "a", "x1", " ", ":="};

  comment_aware_shift_token_scanner u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_hit_line   (out_hit_line),
    .out_hit_column (out_hit_column),
    .out_hit_offset (out_hit_offset)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- lexer
  function automatic void clear_scan();
    scan.mode        = M_NORMAL;
    scan.line        = LINE_BITS_DEF'(1);
    scan.column      = COLUMN_BITS_DEF'(1);
    scan.offset      = '0;
    scan.mark_line   = '0;
    scan.mark_column = '0;
    scan.mark_offset = '0;
    scan.kind        = KIND_NONE;
  endfunction

  // Byte seen in plain text; openers of two-char tokens latch the position
  function automatic void plain_char(input logic [7:0] b);
    bit mark;
    mark = 1'b1;
    case (b)
      CH_QUOTE: begin
        scan.mode = M_STRING;
        mark = 1'b0;
      end
      CH_LBRACE: begin
        scan.mode = M_BRACE;
        mark = 1'b0;
      end
      CH_LPAREN: scan.mode = M_P_PAREN;
      CH_SLASH:  scan.mode = M_P_SLASH;
      CH_LT:     scan.mode = M_P_LT;
      CH_GT:     scan.mode = M_P_GT;
      default: begin
        scan.mode = M_NORMAL;
        mark = 1'b0;
      end
    endcase
    if (mark) begin
      scan.mark_line   = scan.line;
      scan.mark_column = scan.column;
      scan.mark_offset = scan.offset;
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic lst);
    hit_t h;
    if (scan.kind == KIND_NONE) begin
      case (scan.mode)
        M_P_PAREN:   if (b == CH_STAR) scan.mode = M_PAREN; else plain_char(b);
        M_P_SLASH:   if (b == CH_SLASH) scan.mode = M_LINE; else plain_char(b);
        M_P_LT:      if (b == CH_LT) scan.kind = KIND_LT; else plain_char(b);
        M_P_GT:      if (b == CH_GT) scan.kind = KIND_GT; else plain_char(b);
        M_STRING:    if (b == CH_QUOTE) scan.mode = M_STR_QUOTE;
        M_STR_QUOTE: if (b == CH_QUOTE) scan.mode = M_STRING; else plain_char(b);
        M_BRACE:     if (b == CH_RBRACE) scan.mode = M_NORMAL;
        M_PAREN:     if (b == CH_STAR) scan.mode = M_PAREN_STAR;
        M_PAREN_STAR: begin
          if (b == CH_RPAREN) scan.mode = M_NORMAL;
          else if (b != CH_STAR) scan.mode = M_PAREN;
        end
        M_LINE:      if (b == CH_NL) scan.mode = M_NORMAL;
        default:     plain_char(b);
      endcase
    end
    // position counters saturate
    if (scan.offset != '1) scan.offset++;
    if (b == CH_NL) begin
      if (scan.line != '1) scan.line++;
      scan.column = COLUMN_BITS_DEF'(1);
    end else if (scan.column != '1) begin
      scan.column++;
    end
    if (lst) begin
      h = '0;
      if (scan.kind != KIND_NONE) begin
        h.status = scan.kind;
        h.line   = scan.mark_line;
        h.column = scan.mark_column;
        h.offset = scan.mark_offset;
      end
      expected_hits.push_back(h);
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap(src_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last      <= lst;
    do @(posedge clk); while (!in_ready);
    scan_byte(b, lst);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        hold_len--;
        out_ready <= 1'b0;
      end else begin
        if (sink_wait == 0 && sink_idle_on && $urandom_range(0, 3) == 0)
          sink_wait = pick_gap(1'b1);
        if (sink_wait > 0) begin
          sink_wait--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, exp);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_status, 0);
      end else begin
        want = expected_hits.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_hit_line !== want.line)
          report_mismatch("hit_line", out_hit_line, want.line);
        if (out_hit_column !== want.column)
          report_mismatch("hit_column", out_hit_column, want.column);
        if (out_hit_offset !== want.offset)
          report_mismatch("hit_offset", out_hit_offset, want.offset);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
      $display("tb_comment_aware_shift_token_scanner failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_pairs();
    send_text("<<");
    send_text(">>");
    send_text("<");          // pending mark dropped at end of buffer
    send_text("x\n\n <>>");  // '<' then '>' restarts as a '>' mark
    send_text("a>");
  endtask

  task automatic test_strings();
    send_text("'<<''>>'>>");
    send_text("'<'");        // closing quote is the last byte
    send_text("'a<<");       // unclosed string
    send_text("''<<");
  endtask

  task automatic test_comments();
    send_text("{<<}>>");
    send_text("{{}<<");      // no nesting
    send_text("(*)<<*)>>");  // star of the opener does not close
    send_text("(*<<**)>>");
    send_text("//<<\n<<");
    send_text("/<<");
    send_text("(<<");
    send_text("{<<");
  endtask

  task automatic test_after_hit();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("<<");         // ends the buffer, with a hit
    send_byte(CH_GT, 1'b0);
    send_byte(CH_GT, 1'b0);
    send_byte(CH_LBRACE, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_long_line();
    src_idle_on = 1'b0;
    repeat (100) send_byte(8'h61, 1'b0);
    send_text("<<");
    src_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    src_idle_on = 1'b0;
    hold_len    = 300;
    repeat (6) begin
      send_text("<<");
      send_text("ab");
      send_text("\n>>");
    end
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_text(input int n_bytes, input bit with_idle);
    logic [7:0] text_q[$];
    string      frag;
    int         total;
    int         n_frag;
    bit         noisy;
    src_idle_on  = with_idle;
    sink_idle_on = with_idle;
    total = 0;
    while (total < n_bytes) begin
      text_q.delete();
      noisy  = ($urandom_range(0, 9) == 0);
      n_frag = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
      repeat (n_frag) begin
        if (noisy || $urandom_range(0, 9) == 0) begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          frag = frag_tbl[$urandom_range(0, FRAG_N - 1)];
          for (int i = 0; i < frag.len(); i++) text_q.push_back(frag[i]);
        end
      end
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      total += text_q.size();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    mismatches   = 0;
    idle_cycles  = 0;
    hold_len     = 0;
    sink_wait    = 0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    clear_scan();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_last      <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_pairs();
    test_strings();
    test_comments();
    test_after_hit();
    test_long_line();
    test_backpressure();
    test_random_text(350, 1'b1);
    test_random_text(120, 1'b0);

    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_comment_aware_shift_token_scanner passed");
    end else begin
      $display("tb_comment_aware_shift_token_scanner failed");
    end
    $finish;
  end

endmodule
